// ===== hdl/deduplicating_interrupt_queue_unit_defines.svh =====
// Assertion macros shared by the deduplicating interrupt queue RTL.
`ifndef DEDUPLICATING_INTERRUPT_QUEUE_UNIT_DEFINES_SVH
`define DEDUPLICATING_INTERRUPT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication: whenever pre holds, post holds.
`define DIQU_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication: whenever pre holds, post holds in the next cycle.
`define DIQU_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/dique_pkg.sv =====
// Types and codes shared by the deduplicating interrupt queue modules.
package dique_pkg;

  typedef enum logic [1:0] {
    OP_RAISE = 2'd0,
    OP_TAKE  = 2'd1,
    OP_COUNT = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_DUP   = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] irq_number;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] irq_out;
    logic [4:0] pending_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  req_op;
    logic cnt_zero;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/dique_ctrl.sv =====
// Controller state machine for the deduplicating interrupt queue.
module dique_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  dique_pkg::stat_t  stat,
  output dique_pkg::cmd_t   cmd
);

  dique_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dique_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      dique_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          // a raise against a non-empty queue must scan the pending entries
          if (stat.req_op == dique_pkg::OP_RAISE && !stat.cnt_zero) begin
            state_next = dique_pkg::ST_SCAN;
          end else begin
            state_next = dique_pkg::ST_FINISH;
          end
        end
      end
      dique_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = dique_pkg::ST_FINISH;
        end
      end
      dique_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = dique_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dique_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/dique_dp.sv =====
// Datapath of the deduplicating interrupt queue: slot memory, pointers, scan, result register.
`include "deduplicating_interrupt_queue_unit_defines.svh"

module dique_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IRQ_WIDTH   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dique_pkg::req_t   req,
  output dique_pkg::rsp_t   rsp,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  dique_pkg::cmd_t   cmd,
  output dique_pkg::stat_t  stat
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  logic [IRQ_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [IRQ_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]     rd_addr;

  logic [IDX_W-1:0]     head, head_next;
  logic [IDX_W-1:0]     tail, tail_next;
  logic [CNT_W-1:0]     count, count_next;

  dique_pkg::op_t       op_r;
  logic [IRQ_WIDTH-1:0] num_r;
  logic [IDX_W-1:0]     scan_ptr;
  logic [CNT_W-1:0]     scan_left;
  logic                 cmp_pend;
  logic                 match;

  dique_pkg::status_t   status_n;
  logic [7:0]           irq_n;
  logic                 we;

  assign rd_addr = cmd.scan ? scan_ptr : head;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail] <= num_r;
    end
    rd_data <= mem[rd_addr];
  end

  // Capture the request and walk the pending entries, oldest first.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
      match    <= 1'b0;
    end else if (cmd.load) begin
      op_r      <= req.op;
      num_r     <= IRQ_WIDTH'(req.irq_number);
      scan_ptr  <= head;
      scan_left <= count;
      cmp_pend  <= 1'b0;
      match     <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_left != '0) begin
        scan_ptr  <= nxt(scan_ptr);
        scan_left <= scan_left - 1'b1;
        cmp_pend  <= 1'b1;
      end else begin
        cmp_pend  <= 1'b0;
      end
      if (cmp_pend && rd_data == num_r) begin
        match <= 1'b1;
      end
    end
  end

  always_comb begin
    status_n   = dique_pkg::STS_DONE;
    irq_n      = '0;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    unique case (op_r)
      dique_pkg::OP_RAISE: begin
        if (match) begin
          status_n = dique_pkg::STS_DUP;
        end else if (count == CNT_W'(QUEUE_DEPTH)) begin
          status_n = dique_pkg::STS_FULL;
        end else begin
          we         = cmd.finish;
          tail_next  = nxt(tail);
          count_next = count + 1'b1;
        end
      end
      dique_pkg::OP_TAKE: begin
        if (count == '0) begin
          status_n = dique_pkg::STS_EMPTY;
        end else begin
          irq_n      = 8'(rd_data);
          head_next  = nxt(head);
          count_next = count - 1'b1;
        end
      end
      dique_pkg::OP_COUNT: begin
      end
      dique_pkg::OP_CLEAR: begin
        head_next  = tail;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status        <= status_n;
      rsp.irq_out       <= irq_n;
      rsp.pending_count <= 5'(count_next);
    end
  end

  assign stat.req_op    = req.op;
  assign stat.cnt_zero  = (count == '0);
  assign stat.scan_done = (scan_left == '0) && !cmp_pend;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // Pending entries always run contiguously from head to tail.
  logic [IDX_W:0] head_plus;
  logic [IDX_W:0] head_wrap;
  assign head_plus = (IDX_W + 1)'(head) + (IDX_W + 1)'(count);
  assign head_wrap = (head_plus >= (IDX_W + 1)'(QUEUE_DEPTH)) ?
                     head_plus - (IDX_W + 1)'(QUEUE_DEPTH) : head_plus;

  `DIQU_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `DIQU_ASSERT_IMPL(a_ptr_gap, clk, rst, 1'b1, head_wrap[IDX_W-1:0] == tail, "head/count/tail mismatch")
  `DIQU_ASSERT_NEXT(a_finish_out, clk, rst, cmd.finish, rsp_valid, "finish did not load result")

endmodule

// ===== hdl/deduplicating_interrupt_queue_unit.sv =====
// Top level of the deduplicating interrupt queue: controller plus datapath.
//
//   channel | valid     | ready     | payload          | content
//   --------+-----------+-----------+------------------+-------------------------------
//   request | req_valid | req_ready | req (req_t)      | op, irq_number
//   result  | rsp_valid | rsp_ready | rsp (rsp_t)      | status, irq_out, pending_count
//
// A take, count read or clear passes from the accept step straight to the finish step,
// which loads the result register and raises rsp_valid; the result transfer and the
// next request can then overlap. A raise first walks the pending entries, counted
// before the raise, through the single read port of the slot memory; it skips the
// walk and goes straight to the finish step when the queue is empty.
// Reset (rst, synchronous) empties the queue; slot contents are never cleared.
// A stalled result sits in the output register; the next request is still accepted
// and held in its final step until the result register frees up.
module deduplicating_interrupt_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IRQ_WIDTH   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  dique_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output dique_pkg::rsp_t  rsp
);

  // Commands down to the datapath, status back up to the controller.
  dique_pkg::cmd_t  cmd;
  dique_pkg::stat_t stat;

  // Sequence accept, scan and finish steps.
  dique_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the slots and pointers, run the duplicate scan, register the result.
  dique_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IRQ_WIDTH   (IRQ_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
